FILE: rtl/button_gesture_led_controller_core_macros.svh
// Assertion macros for the button gesture LED controller checker.
// No dependencies; included by the checker file.
`ifndef BUTTON_GESTURE_LED_CONTROLLER_CORE_MACROS_SVH
`define BUTTON_GESTURE_LED_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BGLC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bglc assertion failed");

// Next-cycle implication, disabled during reset.
`define BGLC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bglc assertion failed");

`endif

FILE: rtl/bglc_pkg.sv
// Shared constants for the button gesture LED controller.
// No dependencies; used by the core and its checker.
`default_nettype none

package bglc_pkg;

    localparam int CNT_W    = 16;
    localparam int BLINK_W  = 8;
    localparam int PRESS_W  = 2;
    localparam int TDATA_W  = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [CNT_W-1:0]   CNT_MAX            = 16'hFFFF;
    localparam logic [CNT_W-1:0]   HOLD_TICKS_RST     = 16'd200;
    localparam logic [CNT_W-1:0]   DOUBLE_WINDOW_RST  = 16'd50;
    localparam logic [BLINK_W-1:0] BLINK0_LIMIT       = 8'd100;
    localparam logic [BLINK_W-1:0] BLINK1_LIMIT       = 8'd200;
    localparam logic [PRESS_W-1:0] DOUBLE_PRESSES     = 2'd2;
    localparam logic [PRESS_W-1:0] FIRST_PRESS        = 2'd1;

    // Register select, taken from paddr[2]
    localparam logic REG_HOLD_TICKS    = 1'b0;
    localparam logic REG_DOUBLE_WINDOW = 1'b1;

    // Bit positions within the data words
    localparam int BTN0_BIT = 0;
    localparam int BTN1_BIT = 1;
    localparam int LED0_BIT = 0;
    localparam int LED1_BIT = 1;
    localparam int EXIT_BIT = 2;

endpackage

`default_nettype wire

FILE: rtl/button_gesture_led_controller_core.sv
// Button gesture LED controller: press toggle, long press and double press blink.
// Depends on bglc_pkg.
//
// One input transfer is one tick of two active-low button levels; every tick yields
// exactly one result transfer carrying both LED states and the exit flag. The tick's
// whole update runs combinationally from the input port into the state and result
// registers, so one transfer is taken every cycle unless the output is stalled, and
// its result appears on the output in the next cycle. The result register is the
// only buffer: input ready falls only while a result waits and output is stalled.
`default_nettype none

module button_gesture_led_controller_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // tdata: [0] button0_level, [1] button1_level, [7:2] zero
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    input  wire logic [bglc_pkg::TDATA_W-1:0]    s_axis_tdata,
    // tdata: [0] led0_on, [1] led1_on, [2] exit_request, [7:3] zero
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [bglc_pkg::TDATA_W-1:0]    m_axis_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bglc_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [bglc_pkg::PDATA_W-1:0]    pwdata,
    output      logic [bglc_pkg::PDATA_W-1:0]    prdata,
    output      logic                            pready
);

    logic [bglc_pkg::CNT_W-1:0]   hold_ticks_reg;
    logic [bglc_pkg::CNT_W-1:0]   double_window_reg;

    logic [bglc_pkg::CNT_W-1:0]   hold_count_reg,    hold_count_next;
    logic                         blink0_active_reg, blink0_active_next;
    logic [bglc_pkg::BLINK_W-1:0] blink0_count_reg,  blink0_count_next;
    logic                         prev0_released_reg;
    logic                         toggle0_phase_reg, toggle0_phase_next;
    logic [bglc_pkg::PRESS_W-1:0] press_count1_reg,  press_count1_next;
    logic [bglc_pkg::CNT_W-1:0]   window_count_reg,  window_count_next;
    logic                         blink1_active_reg, blink1_active_next;
    logic [bglc_pkg::BLINK_W-1:0] blink1_count_reg,  blink1_count_next;
    logic                         prev1_released_reg;
    logic                         toggle1_phase_reg, toggle1_phase_next;
    logic                         led0_reg,          led0_next;
    logic                         led1_reg,          led1_next;
    logic                         exit_next;

    logic                         out_valid_reg,     out_valid_next;
    logic [bglc_pkg::TDATA_W-1:0] out_data_reg;

    logic                         down0, down1, press0, press1;
    logic                         in_xfer, cfg_write;

    assign pready        = 1'b1;
    assign cfg_write     = psel & penable & pwrite & pready;
    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign in_xfer       = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign down0  = ~s_axis_tdata[bglc_pkg::BTN0_BIT];
    assign down1  = ~s_axis_tdata[bglc_pkg::BTN1_BIT];
    assign press0 = down0 & prev0_released_reg;
    assign press1 = down1 & prev1_released_reg;

    always_comb
    begin
        unique case (paddr[2])
            bglc_pkg::REG_HOLD_TICKS:
            begin
                prdata = {{(bglc_pkg::PDATA_W-bglc_pkg::CNT_W){1'b0}}, hold_ticks_reg};
            end
            bglc_pkg::REG_DOUBLE_WINDOW:
            begin
                prdata = {{(bglc_pkg::PDATA_W-bglc_pkg::CNT_W){1'b0}}, double_window_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg    <= bglc_pkg::HOLD_TICKS_RST;
            double_window_reg <= bglc_pkg::DOUBLE_WINDOW_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                bglc_pkg::REG_HOLD_TICKS:
                begin
                    hold_ticks_reg <= pwdata[bglc_pkg::CNT_W-1:0];
                end
                bglc_pkg::REG_DOUBLE_WINDOW:
                begin
                    double_window_reg <= pwdata[bglc_pkg::CNT_W-1:0];
                end
                default:
                begin
                    hold_ticks_reg <= hold_ticks_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        // Button 0: hold, blink, press toggle
        if (!down0)
        begin
            hold_count_next = '0;
        end
        else if (hold_count_reg == bglc_pkg::CNT_MAX)
        begin
            hold_count_next = hold_count_reg;
        end
        else
        begin
            hold_count_next = hold_count_reg + 16'd1;
        end
        blink0_active_next = blink0_active_reg | (hold_count_next == hold_ticks_reg);
        blink0_count_next  = blink0_count_reg;
        led0_next          = led0_reg;
        if (blink0_active_next)
        begin
            blink0_count_next = blink0_count_reg + 8'd1;
            if (blink0_count_next > bglc_pkg::BLINK0_LIMIT)
            begin
                led0_next         = ~led0_next;
                blink0_count_next = '0;
            end
        end
        toggle0_phase_next = toggle0_phase_reg;
        if (press0)
        begin
            blink0_active_next = 1'b0;
            hold_count_next    = '0;
            toggle0_phase_next = ~toggle0_phase_reg;
            led0_next          = toggle0_phase_next ? 1'b0 : ~led0_next;
        end

        // Button 1: double-press window, blink, press toggle
        press_count1_next = press_count1_reg;
        window_count_next = window_count_reg;
        if ((press_count1_reg == bglc_pkg::FIRST_PRESS) &&
            (window_count_reg != bglc_pkg::CNT_MAX))
        begin
            window_count_next = window_count_reg + 16'd1;
        end
        if (window_count_next > double_window_reg)
        begin
            press_count1_next = '0;
            window_count_next = '0;
        end
        blink1_active_next = blink1_active_reg;
        if ((press_count1_next == bglc_pkg::DOUBLE_PRESSES) &&
            (window_count_next <= double_window_reg))
        begin
            blink1_active_next = 1'b1;
            window_count_next  = '0;
            press_count1_next  = '0;
        end
        blink1_count_next = blink1_count_reg;
        led1_next         = led1_reg;
        if (blink1_active_next)
        begin
            blink1_count_next = blink1_count_reg + 8'd1;
            if (blink1_count_next > bglc_pkg::BLINK1_LIMIT)
            begin
                led1_next         = ~led1_next;
                blink1_count_next = '0;
            end
        end
        toggle1_phase_next = toggle1_phase_reg;
        if (press1)
        begin
            blink1_active_next = 1'b0;
            toggle1_phase_next = ~toggle1_phase_reg;
            press_count1_next  = press_count1_next + 2'd1;
            led1_next          = toggle1_phase_next ? 1'b0 : ~led1_next;
        end

        // Both down: clear and request exit
        exit_next = down0 & down1;
        if (exit_next)
        begin
            led0_next = 1'b0;
            led1_next = 1'b0;
        end

        out_valid_next = in_xfer | (out_valid_reg & ~m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg     <= '0;
            blink0_active_reg  <= 1'b0;
            blink0_count_reg   <= '0;
            prev0_released_reg <= 1'b1;
            toggle0_phase_reg  <= 1'b1;
            press_count1_reg   <= '0;
            window_count_reg   <= '0;
            blink1_active_reg  <= 1'b0;
            blink1_count_reg   <= '0;
            prev1_released_reg <= 1'b1;
            toggle1_phase_reg  <= 1'b1;
            led0_reg           <= 1'b0;
            led1_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                hold_count_reg     <= hold_count_next;
                blink0_active_reg  <= blink0_active_next;
                blink0_count_reg   <= blink0_count_next;
                prev0_released_reg <= ~down0;
                toggle0_phase_reg  <= toggle0_phase_next;
                press_count1_reg   <= press_count1_next;
                window_count_reg   <= window_count_next;
                blink1_active_reg  <= blink1_active_next;
                blink1_count_reg   <= blink1_count_next;
                prev1_released_reg <= ~down1;
                toggle1_phase_reg  <= toggle1_phase_next;
                led0_reg           <= led0_next;
                led1_reg           <= led1_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg <= {{(bglc_pkg::TDATA_W-3){1'b0}}, exit_next, led1_next, led0_next};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bglc_checker.sv
// Port-level checker for the button gesture LED controller, bound to the core.
// Depends on bglc_pkg and button_gesture_led_controller_core_macros.svh.
`default_nettype none

`include "button_gesture_led_controller_core_macros.svh"

module bglc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic [bglc_pkg::TDATA_W-1:0] s_axis_tdata,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [bglc_pkg::TDATA_W-1:0] m_axis_tdata,
    input wire logic                         pready
);

    `BGLC_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `BGLC_ASSERT_IMP(a_exit_clears, clk, rst_n, m_axis_tvalid && m_axis_tdata[bglc_pkg::EXIT_BIT], !m_axis_tdata[bglc_pkg::LED0_BIT] && !m_axis_tdata[bglc_pkg::LED1_BIT])
    `BGLC_ASSERT_NXT(a_exit_follows, clk, rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid && (m_axis_tdata[bglc_pkg::EXIT_BIT] == ($past(!s_axis_tdata[bglc_pkg::BTN0_BIT]) && $past(!s_axis_tdata[bglc_pkg::BTN1_BIT]))))
    `BGLC_ASSERT_IMP(a_ready_free, clk, rst_n, !m_axis_tvalid, s_axis_tready && pready)

endmodule

bind button_gesture_led_controller_core bglc_checker u_bglc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

`default_nettype wire
